// ===== rtl/radix_digit_converter_core_defines.svh =====
// Assertion macros for the radix digit converter core.
// Used by files under rtl that write concurrent assertions; no other dependencies.
`ifndef RADIX_DIGIT_CONVERTER_CORE_DEFINES_SVH
`define RADIX_DIGIT_CONVERTER_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define RDC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define RDC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/rdc_pkg.sv =====
// Package for the radix digit converter: request/result types, status codes,
// reciprocal table and a function for the saturation value. No dependencies.
package rdc_pkg;

  typedef struct packed {
    logic [3:0]  from_base;
    logic [3:0]  to_base;
    logic [29:0] number;
  } req_t;

  typedef struct packed {
    logic [63:0] converted;
    logic [1:0]  status;
  } rsp_t;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BADBASE  = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  localparam logic [3:0] BASE_MIN = 4'd2;
  localparam logic [3:0] BASE_MAX = 4'd10;
  localparam logic [3:0] TEN      = 4'd10;

  // floor(2^32 / b) for the legal bases
  function automatic logic [31:0] recip(input logic [3:0] b);
    logic [31:0] r;
    unique case (b)
      4'd2:    r = 32'h8000_0000;
      4'd3:    r = 32'h5555_5555;
      4'd4:    r = 32'h4000_0000;
      4'd5:    r = 32'h3333_3333;
      4'd6:    r = 32'h2AAA_AAAA;
      4'd7:    r = 32'h2492_4924;
      4'd8:    r = 32'h2000_0000;
      4'd9:    r = 32'h1C71_C71C;
      4'd10:   r = 32'h1999_9999;
      default: r = 32'h0000_0000;
    endcase
    return r;
  endfunction

  // n decimal nines
  function automatic logic [63:0] nines(input int n);
    logic [63:0] p;
    p = 64'd1;
    for (int i = 0; i < n; i++) begin
      p = p * 64'd10;
    end
    return p - 64'd1;
  endfunction

endpackage

// ===== rtl/radix_digit_converter_core.sv =====
// Radix digit converter core: sequencer around one shared divide-by-small unit.
// Depends on rdc_pkg and radix_digit_converter_core_defines.svh.
//
// A request is taken when start is high and busy is low. A bad base answers on
// done in the next cycle and leaves the core free. Otherwise the core stays busy:
// each decimal input digit and each output digit goes through the shared divide
// unit as a reciprocal multiply, then a remainder correction, and each phase is
// closed by a flush step before the core goes on. On overflow the core stops
// after OUT_DIGITS digits without closing the second phase and reports the
// saturated value. done is high for exactly one cycle and the result must be
// captured then; the core never waits on it.
`include "radix_digit_converter_core_defines.svh"

module radix_digit_converter_core
  import rdc_pkg::*;
#(
  parameter int IN_DIGITS  = 9,
  parameter int OUT_DIGITS = 19
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  req_t request,
  output logic done,
  output rsp_t result
);

  localparam int CNT_MAX = (IN_DIGITS > OUT_DIGITS) ? IN_DIGITS : OUT_DIGITS;
  localparam int CNT_W = $clog2(CNT_MAX + 1);
  localparam logic [CNT_W-1:0] IN_LAST = CNT_W'(IN_DIGITS);
  localparam logic [CNT_W-1:0] OUT_LAST = CNT_W'(OUT_DIGITS);
  localparam logic [63:0] SAT_VALUE = nines(OUT_DIGITS);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_MUL   = 2'd1;
  localparam logic [1:0] S_FIX   = 2'd2;
  localparam logic [1:0] S_FLUSH = 2'd3;

  logic [1:0]       state;
  logic             pend;
  logic             conv;
  logic [CNT_W-1:0] cnt;
  logic [29:0]      t;
  logic [3:0]       divisor;
  logic [3:0]       to_b;
  logic [29:0]      qest;
  logic [3:0]       r;
  logic [63:0]      acc;
  logic [63:0]      scale;
  logic [3:0]       mulby;

  logic             bad_base;
  logic [61:0]      prod;
  logic [33:0]      qb;
  logic [33:0]      rem_full;
  logic [4:0]       rem;
  logic [4:0]       div2;
  logic             fix_ge;
  logic [29:0]      q_fix;
  logic [3:0]       r_fix;
  logic [CNT_W-1:0] cnt_inc;
  logic [63:0]      acc_sum;
  logic [63:0]      scale_mul;

  assign busy = (state != S_IDLE);

  assign bad_base = (request.from_base < BASE_MIN) || (request.from_base > BASE_MAX) ||
                    (request.to_base < BASE_MIN) || (request.to_base > BASE_MAX);

  assign prod      = 62'(t) * 62'(recip(divisor));
  assign qb        = 34'(qest) * 34'(divisor);
  assign rem_full  = 34'(t) - qb;
  assign rem       = rem_full[4:0];
  assign div2      = {divisor, 1'b0};
  assign fix_ge    = (rem >= {1'b0, divisor});
  assign q_fix     = fix_ge ? (qest + 30'd1) : qest;
  assign r_fix     = fix_ge ? 4'(rem - {1'b0, divisor}) : rem[3:0];
  assign cnt_inc   = cnt + 1'b1;
  assign acc_sum   = acc + (scale * 64'(r));
  assign scale_mul = scale * 64'(mulby);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
      pend  <= 1'b0;
      conv  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            if (bad_base) begin
              result <= '{converted: 64'd0, status: ST_BADBASE};
              done   <= 1'b1;
            end else begin
              t       <= request.number;
              divisor <= TEN;
              to_b    <= request.to_base;
              mulby   <= request.from_base;
              acc     <= 64'd0;
              scale   <= 64'd1;
              cnt     <= '0;
              pend    <= 1'b0;
              conv    <= 1'b0;
              state   <= S_MUL;
            end
          end
        end
        S_MUL: begin
          qest <= prod[61:32];
          if (pend) begin
            acc   <= acc_sum;
            scale <= scale_mul;
            pend  <= 1'b0;
          end
          state <= S_FIX;
        end
        S_FIX: begin
          t    <= q_fix;
          r    <= r_fix;
          pend <= 1'b1;
          cnt  <= cnt_inc;
          if (!conv) begin
            state <= (cnt_inc == IN_LAST) ? S_FLUSH : S_MUL;
          end else if (q_fix == 30'd0) begin
            state <= S_FLUSH;
          end else if (cnt_inc == OUT_LAST) begin
            result <= '{converted: SAT_VALUE, status: ST_OVERFLOW};
            done   <= 1'b1;
            pend   <= 1'b0;
            state  <= S_IDLE;
          end else begin
            state <= S_MUL;
          end
        end
        S_FLUSH: begin
          pend <= 1'b0;
          if (!conv) begin
            t       <= acc_sum[29:0];
            divisor <= to_b;
            mulby   <= TEN;
            acc     <= 64'd0;
            scale   <= 64'd1;
            cnt     <= '0;
            conv    <= 1'b1;
            state   <= S_MUL;
          end else begin
            result <= '{converted: acc_sum, status: ST_OK};
            done   <= 1'b1;
            state  <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `RDC_ASSERT_SAME(a_done_idle, clk, rst, done, !busy, "result strobed while busy")
  `RDC_ASSERT_SAME(a_rem_bound, clk, rst, state == S_FIX, rem_full < 34'(div2),
                   "reciprocal quotient off by more than one")
  `RDC_ASSERT_NEXT(a_bad_base, clk, rst, start && !busy && bad_base,
                   done && (result.status == ST_BADBASE), "bad base not reported")
  `RDC_ASSERT_SAME(a_divisor_ok, clk, rst, busy,
                   (divisor >= BASE_MIN) && (divisor <= BASE_MAX), "divisor out of range")

endmodule
